[hdl/rpn_pkg.sv]
// Shared types, constants and helpers for the postfix expression evaluator.
`timescale 1ns / 1ps

package rpn_pkg;

   // Default sizing handed to the top level
   localparam int DEF_STACK_DEPTH = 16;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   // Fixed payload widths
   localparam int CH_W    = 8;
   localparam int TOP_W   = 32;
   localparam int DEPTH_W = 5;
   localparam int ERR_W   = 3;

   // Character codes
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

   // Error codes reported with each item
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_DIVZERO   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_BADCHAR   = 3'd4;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [1:0] {
      AST_IDLE,
      AST_RUN,
      AST_FIN
   } alu_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_BIN_CHECK,
      ST_RD_A,
      ST_CAP_A,
      ST_ALU_GO,
      ST_ALU_WAIT,
      ST_TOP_RD,
      ST_TOP_CAP,
      ST_RESP
   } seq_state_type;

   function automatic logic is_digit(input logic [CH_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

[hdl/rpn_req_if.sv]
// Input channel: one expression character per item.
`timescale 1ns / 1ps

interface rpn_req_if import rpn_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            last;

   modport source (output valid, ch, last, input ready);
   modport sink   (input valid, ch, last, output ready);
endinterface

[hdl/rpn_rsp_if.sv]
// Result channel: top of stack, depth, error and end marker per item.
`timescale 1ns / 1ps

interface rpn_rsp_if import rpn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [TOP_W-1:0] top_value;
   logic [DEPTH_W-1:0]      depth;
   logic [ERR_W-1:0]        error;
   logic                    done_res;

   modport source (output valid, top_value, depth, error, done_res, input ready);
   modport sink   (input valid, top_value, depth, error, done_res, output ready);
endinterface

[hdl/rpn_stack.sv]
// Value stack storage: one write port, one registered read port.
`timescale 1ns / 1ps

module rpn_stack import rpn_pkg::*; #(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   input  logic [VALUE_WIDTH-1:0]         wr_data,
   input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   output logic [VALUE_WIDTH-1:0]         rd_data
);

   logic [VALUE_WIDTH-1:0] entry_mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rpn_alu.sv]
// Shared fixed-point unit: saturating add/sub in one step, shift-add multiply
// and restoring divide one bit per cycle.
`timescale 1ns / 1ps

module rpn_alu import rpn_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  alu_ctl_type            ctl,
   input  logic [VALUE_WIDTH-1:0] a_op,
   input  logic [VALUE_WIDTH-1:0] b_op,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int W      = VALUE_WIDTH;
   localparam int PROD_W = 2 * W;
   localparam int DIV_N  = W + FRAC_BITS;
   localparam int MAG_W  = (PROD_W > DIV_N) ? PROD_W : DIV_N;
   localparam int CNT_W  = $clog2(MAG_W + 1);

   alu_state_type      state_ff, state_in;
   alu_op_type         op_ff, op_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [W-1:0]       mcand_ff, mcand_in;
   logic [DIV_N-1:0]   num_ff, num_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [DIV_N-1:0]   quo_ff, quo_in;
   logic [W-1:0]       result_ff, result_in;
   logic               done_ff, done_in;

   logic               a_neg, b_neg;
   logic [W-1:0]       a_mag, b_mag;
   logic [W:0]         sum_a, sum_b, sum;
   logic [W-1:0]       sum_sat;
   logic [W:0]         mul_hi;
   logic [PROD_W-1:0]  acc_step;
   logic [W:0]         r_sh, r_dif;
   logic               r_ge;
   logic [MAG_W-1:0]   mag_raw, lim;
   logic               ovf;
   logic [W-1:0]       mag_c, fin_val;

   // Operand unpacking and the single-step add/sub with saturation
   always_comb begin
      a_neg = a_op[W-1];
      b_neg = b_op[W-1];
      a_mag = a_neg ? (~a_op + 1'b1) : a_op;
      b_mag = b_neg ? (~b_op + 1'b1) : b_op;
      sum_a = {a_op[W-1], a_op};
      sum_b = {b_op[W-1], b_op};
      sum   = (ctl.op == ALU_SUB) ? (sum_a - sum_b) : (sum_a + sum_b);
      if (sum[W] != sum[W-1]) begin
         sum_sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         sum_sat = sum[W-1:0];
      end
   end

   // One multiply step: add multiplicand to upper half, shift right
   always_comb begin
      mul_hi   = {1'b0, acc_ff[PROD_W-1:W]} + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
      acc_step = {mul_hi, acc_ff[W-1:1]};
   end

   // One divide step: shift in next numerator bit, trial subtract
   always_comb begin
      r_sh  = {rem_ff, num_ff[DIV_N-1]};
      r_ge  = r_sh >= {1'b0, mcand_ff};
      r_dif = r_sh - {1'b0, mcand_ff};
   end

   // Final scaling, clamp to the signed range and re-apply sign
   always_comb begin
      if (op_ff == ALU_MUL) begin
         mag_raw = MAG_W'(acc_ff >> FRAC_BITS);
      end else begin
         mag_raw = MAG_W'(quo_ff);
      end
      lim     = MAG_W'({1'b0, {(W-1){1'b1}}}) + MAG_W'(neg_ff);
      ovf     = mag_raw > lim;
      mag_c   = ovf ? lim[W-1:0] : mag_raw[W-1:0];
      fin_val = neg_ff ? (~mag_c + 1'b1) : mag_c;
   end

   // Sequencer of the unit
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         AST_IDLE: begin
            if (ctl.start) begin
               op_in  = ctl.op;
               neg_in = a_neg ^ b_neg;
               case (ctl.op)
                  ALU_ADD, ALU_SUB: begin
                     result_in = sum_sat;
                     done_in   = 1'b1;
                  end
                  ALU_MUL: begin
                     acc_in   = PROD_W'(a_mag);
                     mcand_in = b_mag;
                     cnt_in   = CNT_W'(W);
                     state_in = AST_RUN;
                  end
                  ALU_DIV: begin
                     num_in   = DIV_N'(a_mag) << FRAC_BITS;
                     mcand_in = b_mag;
                     rem_in   = '0;
                     quo_in   = '0;
                     cnt_in   = CNT_W'(DIV_N);
                     state_in = AST_RUN;
                  end
                  default: begin
                     state_in = AST_IDLE;
                  end
               endcase
            end
         end
         AST_RUN: begin
            if (cnt_ff == '0) begin
               state_in = AST_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (op_ff == ALU_MUL) begin
                  acc_in = acc_step;
               end else begin
                  rem_in = r_ge ? r_dif[W-1:0] : r_sh[W-1:0];
                  quo_in = {quo_ff[DIV_N-2:0], r_ge};
                  num_in = num_ff << 1;
               end
            end
         end
         AST_FIN: begin
            result_in = fin_val;
            done_in   = 1'b1;
            state_in  = AST_IDLE;
         end
         default: begin
            state_in = AST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[hdl/rpn_stack_evaluator_top.sv]
// Postfix expression evaluator top level: character sequencer, stack and ALU.
//
// Takes one ASCII character per item and returns one result per item: the top
// of the stack (signed fixed point, Q16.16 at the default sizing, sign-extended
// or cut to 32 bits), the depth, an error code and the end marker. The input is
// ready only while the sequencer is idle. How long an item takes depends on the
// character: the top read is skipped when the stack is empty, and the time is
// set by the shared ALU, which handles one product or quotient bit per cycle,
// and by the single read port of the stack memory. A minus held over from the
// previous character is first carried out as a subtraction through the ALU
// when the character that follows is not a digit. A finished result waits in
// an output register, so the next character can be taken while it is still
// being collected.
`timescale 1ns / 1ps

module rpn_stack_evaluator_top import rpn_pkg::*; #(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   rpn_req_if.sink   req_chan,
   rpn_rsp_if.source rsp_chan
);

   localparam int W    = VALUE_WIDTH;
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int EW   = W + FRAC_BITS + 4;

   seq_state_type           state_ff, state_in;
   logic [CH_W-1:0]         ch_ff, ch_in;
   logic                    last_ff, last_in;
   logic [ERR_W-1:0]        err_ff, err_in;
   alu_op_type              op_ff, op_in;
   logic                    pre_ff, pre_in;
   logic                    pending_ff, pending_in;
   logic [SP_W-1:0]         sp_ff, sp_in;
   logic [W-1:0]            a_ff, a_in;
   logic [W-1:0]            b_ff, b_in;
   logic [W-1:0]            top_ff, top_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [TOP_W-1:0] rsp_top_ff;
   logic [DEPTH_W-1:0]      rsp_depth_ff;
   logic [ERR_W-1:0]        rsp_err_ff;
   logic                    rsp_done_ff;

   logic                    rsp_load;
   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [W-1:0]            mem_wr_data;
   logic [AW-1:0]           mem_rd_addr;
   logic [W-1:0]            mem_rd_data;
   alu_ctl_type             alu_ctl;
   logic                    alu_done;
   logic [W-1:0]            alu_result;

   logic [SP_W-1:0]         sp_m1, sp_m2;
   seq_state_type           after_op;
   logic [3:0]              digit_val;
   logic [EW-1:0]           dig_mag, dig_lim;
   logic [W-1:0]            dig_clamp, dig_value;
   logic [W+TOP_W-1:0]      top_ext;
   logic [SP_W+DEPTH_W-1:0] sp_ext;

   function automatic logic [ERR_W-1:0] err_merge(input logic [ERR_W-1:0] cur,
                                                  input logic [ERR_W-1:0] code);
      return (cur == ERR_NONE) ? code : cur;
   endfunction

   rpn_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rpn_alu #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a_op   (a_ff),
      .b_op   (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // Stack addresses, digit value with saturation and sign, output formatting
   always_comb begin
      sp_m1     = sp_ff - 1'b1;
      sp_m2     = sp_ff - 2'd2;
      after_op  = pre_ff ? ST_DISPATCH : ST_TOP_RD;
      digit_val = 4'(ch_ff - CH_ZERO);
      dig_mag   = EW'(digit_val) << FRAC_BITS;
      dig_lim   = EW'({1'b0, {(W-1){1'b1}}}) + EW'(pending_ff);
      dig_clamp = (dig_mag > dig_lim) ? dig_lim[W-1:0] : dig_mag[W-1:0];
      dig_value = pending_ff ? (~dig_clamp + 1'b1) : dig_clamp;
      top_ext   = {{TOP_W{top_ff[W-1]}}, top_ff};
      sp_ext    = (SP_W + DEPTH_W)'(sp_ff);
   end

   // Character sequencer
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      last_in       = last_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      pre_in        = pre_ff;
      pending_in    = pending_ff;
      sp_in         = sp_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      top_in        = top_ff;
      rsp_load      = 1'b0;
      req_chan.ready = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = sp_ff[AW-1:0];
      mem_wr_data   = dig_value;
      mem_rd_addr   = sp_m1[AW-1:0];
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               ch_in   = req_chan.ch;
               last_in = req_chan.last;
               err_in  = ERR_NONE;
               if (pending_ff && !is_digit(req_chan.ch)) begin
                  // held minus turns into a subtraction first
                  pending_in = 1'b0;
                  op_in      = ALU_SUB;
                  pre_in     = 1'b1;
                  state_in   = ST_BIN_CHECK;
               end else begin
                  pre_in   = 1'b0;
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_DISPATCH: begin
            pre_in   = 1'b0;
            state_in = ST_TOP_RD;
            if (is_digit(ch_ff)) begin
               if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                  err_in = err_merge(err_ff, ERR_OVERFLOW);
               end else begin
                  mem_wr_en = 1'b1;
                  sp_in     = sp_ff + 1'b1;
               end
               pending_in = 1'b0;
            end else begin
               case (ch_ff)
                  CH_PLUS: begin
                     op_in    = ALU_ADD;
                     state_in = ST_BIN_CHECK;
                  end
                  CH_STAR: begin
                     op_in    = ALU_MUL;
                     state_in = ST_BIN_CHECK;
                  end
                  CH_SLASH: begin
                     op_in    = ALU_DIV;
                     state_in = ST_BIN_CHECK;
                  end
                  CH_MINUS: begin
                     if (last_ff) begin
                        op_in    = ALU_SUB;
                        state_in = ST_BIN_CHECK;
                     end else begin
                        pending_in = 1'b1;
                     end
                  end
                  CH_SPACE: begin
                     state_in = ST_TOP_RD;
                  end
                  default: begin
                     err_in = err_merge(err_ff, ERR_BADCHAR);
                  end
               endcase
            end
         end
         ST_BIN_CHECK: begin
            if (sp_ff < SP_W'(2)) begin
               err_in   = err_merge(err_ff, ERR_UNDERFLOW);
               state_in = after_op;
            end else begin
               mem_rd_addr = sp_m1[AW-1:0];
               state_in    = ST_RD_A;
            end
         end
         ST_RD_A: begin
            b_in        = mem_rd_data;
            mem_rd_addr = sp_m2[AW-1:0];
            state_in    = ST_CAP_A;
         end
         ST_CAP_A: begin
            a_in = mem_rd_data;
            if ((op_ff == ALU_DIV) && (b_ff == '0)) begin
               err_in   = err_merge(err_ff, ERR_DIVZERO);
               state_in = after_op;
            end else begin
               state_in = ST_ALU_GO;
            end
         end
         ST_ALU_GO: begin
            alu_ctl.start = 1'b1;
            state_in      = ST_ALU_WAIT;
         end
         ST_ALU_WAIT: begin
            if (alu_done) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = sp_m2[AW-1:0];
               mem_wr_data = alu_result;
               sp_in       = sp_m1;
               state_in    = after_op;
            end
         end
         ST_TOP_RD: begin
            if (sp_ff != '0) begin
               mem_rd_addr = sp_m1[AW-1:0];
               state_in    = ST_TOP_CAP;
            end else begin
               top_in   = '0;
               state_in = ST_RESP;
            end
         end
         ST_TOP_CAP: begin
            top_in   = mem_rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               if (last_ff) begin
                  sp_in      = '0;
                  pending_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register handshake
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and operand registers
   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      last_ff <= last_in;
      err_ff  <= err_in;
      op_ff   <= op_in;
      pre_ff  <= pre_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      top_ff  <= top_in;
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_top_ff   <= signed'(top_ext[TOP_W-1:0]);
         rsp_depth_ff <= sp_ext[DEPTH_W-1:0];
         rsp_err_ff   <= err_ff;
         rsp_done_ff  <= last_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.top_value = rsp_top_ff;
   assign rsp_chan.depth     = rsp_depth_ff;
   assign rsp_chan.error     = rsp_err_ff;
   assign rsp_chan.done_res  = rsp_done_ff;

   // Stack pointer never passes the stack size
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack size");

   // The item that ends an expression leaves an empty stack
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_ff) |=> (sp_ff == '0) && !pending_ff)
      else $error("stack not cleared after last item");

   // An overflow report only comes from a full stack
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (err_ff == ERR_OVERFLOW)) |-> (sp_ff == SP_W'(STACK_DEPTH)))
      else $error("overflow reported with room on the stack");

   // The ALU only finishes while the sequencer waits for it
   a_alu_done_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == ST_ALU_WAIT))
      else $error("ALU result arrived outside the wait state");

endmodule
